// ----- hw/rtl/ilp_pkg.sv -----
package ilp_pkg;

	localparam int unsigned CharW  = 8;
	localparam int unsigned ValueW = 64;
	localparam int unsigned DigitW = 4;
	localparam int unsigned RadixW = 5;

	// Characters with a meaning to the parser
	localparam logic [CharW-1:0] CharNul   = 8'h00;
	localparam logic [CharW-1:0] CharZero  = 8'h30;
	localparam logic [CharW-1:0] CharMinus = 8'h2D;
	localparam logic [CharW-1:0] CharUnder = 8'h5F;
	localparam logic [CharW-1:0] CharX     = 8'h78;
	localparam logic [CharW-1:0] CharD     = 8'h64;
	localparam logic [CharW-1:0] CharC     = 8'h63;
	localparam logic [CharW-1:0] CharB     = 8'h62;
	localparam logic [CharW-1:0] CharUpperA = 8'h41;
	localparam logic [CharW-1:0] CharLowerA = 8'h61;

	typedef enum logic [8:0] {
		MODE_START = 9'b000000001,
		MODE_ZERO  = 9'b000000010,
		MODE_HEX   = 9'b000000100,
		MODE_DEC_P = 9'b000001000,
		MODE_OCT_P = 9'b000010000,
		MODE_BIN_P = 9'b000100000,
		MODE_OCT_L = 9'b001000000,
		MODE_DEC   = 9'b010000000,
		MODE_HALT  = 9'b100000000
	} mode_t;

	typedef enum logic [1:0] {
		BASE_BIN = 2'd0,
		BASE_OCT = 2'd1,
		BASE_DEC = 2'd2,
		BASE_HEX = 2'd3
	} base_t;

	typedef struct packed {
		logic              ok;
		logic [DigitW-1:0] val;
	} digit_t;

	function automatic logic [RadixW-1:0] radix(input base_t b);
		logic [RadixW-1:0] r;
		case (b)
			BASE_BIN: r = 5'd2;
			BASE_OCT: r = 5'd8;
			BASE_DEC: r = 5'd10;
			BASE_HEX: r = 5'd16;
			default:  r = 5'd16;
		endcase
		return r;
	endfunction

endpackage

// ----- hw/rtl/ilp_ch_if.sv -----
interface ilp_ch_if;
	logic                          valid;
	logic                          ready;
	logic [ilp_pkg::CharW-1:0]     ch;

	modport source (output valid, output ch, input ready);
	modport sink (input valid, input ch, output ready);
endinterface

// ----- hw/rtl/ilp_value_if.sv -----
interface ilp_value_if;
	logic                              valid;
	logic                              ready;
	logic signed [ilp_pkg::ValueW-1:0] value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

// ----- hw/rtl/ilp_digit.sv -----
// Decode one character as a digit of the selected base.
module ilp_digit (
	input  logic [ilp_pkg::CharW-1:0] ch,
	input  ilp_pkg::base_t            base,
	output ilp_pkg::digit_t           dig
);

	logic [ilp_pkg::CharW-1:0] raw;
	logic                      is_digit;

	always_comb begin
		raw      = '0;
		is_digit = 1'b1;
		if (ch inside {[8'h30:8'h39]}) begin
			raw = ch - ilp_pkg::CharZero;
		end else if (ch inside {[8'h41:8'h46]}) begin
			raw = ch - ilp_pkg::CharUpperA + 8'd10;
		end else if (ch inside {[8'h61:8'h66]}) begin
			raw = ch - ilp_pkg::CharLowerA + 8'd10;
		end else begin
			is_digit = 1'b0;
		end
		dig.val = raw[ilp_pkg::DigitW-1:0];
		dig.ok  = is_digit && ({1'b0, raw[ilp_pkg::DigitW-1:0]} < ilp_pkg::radix(base));
	end

endmodule

// ----- hw/rtl/integer_literal_parser_unit.sv -----
// Integer literal parser. Feed a string one byte per request on chars; a zero
// byte ends the string and yields one request on result carrying the parsed
// value as a 64-bit two's complement integer that wraps modulo 2^64. Prefixes
// 0x, 0d, 0c and 0b select hex, decimal, octal and binary with underscores
// skipped; a bare leading 0 selects legacy octal without underscore skipping;
// anything else is decimal with an optional leading minus. In hex a non-digit
// counts as a zero digit; in the other bases an invalid character freezes the
// value until the terminating zero. The mode, sign and accumulator registers
// are updated by a single shift-add per byte, so a byte may be accepted on
// every clock while chars ready is high. The result sits in an output register
// loaded on the clock edge that accepts the zero byte. While a result
// is held and result ready is low, chars ready is low for every byte, not only
// for a zero byte; in the cycle the held result is taken, chars ready is high
// again, so back-to-back strings run at full rate when the result side keeps
// ready high.
module integer_literal_parser_unit (
	input  logic         clk,
	input  logic         arst_n,
	ilp_ch_if.sink       chars,
	ilp_value_if.source  result
);

	ilp_pkg::mode_t               mode_q, mode_d;
	logic                         neg_q, neg_d;
	logic [ilp_pkg::ValueW-1:0]   accum_q, accum_d;
	logic [ilp_pkg::ValueW-1:0]   scaled;
	logic                         res_valid_q;
	logic [ilp_pkg::ValueW-1:0]   res_value_q;
	logic                         acc;
	logic                         step;
	ilp_pkg::base_t               base;
	ilp_pkg::digit_t              dig;

	// Accept while the output register is empty or being drained.
	assign chars.ready  = !res_valid_q || result.ready;
	assign acc          = chars.valid && chars.ready;
	assign result.valid = res_valid_q;
	assign result.value = res_value_q;

	ilp_digit u_digit (
		.ch   (chars.ch),
		.base (base),
		.dig  (dig)
	);

	// Shift-add scaling of the accumulator by the current base.
	always_comb begin
		case (base)
			ilp_pkg::BASE_BIN: scaled = accum_q << 1;
			ilp_pkg::BASE_OCT: scaled = accum_q << 3;
			ilp_pkg::BASE_DEC: scaled = (accum_q << 3) + (accum_q << 1);
			ilp_pkg::BASE_HEX: scaled = accum_q << 4;
			default:           scaled = accum_q << 4;
		endcase
	end

	// Next state for one non-terminating byte.
	always_comb begin
		mode_d  = mode_q;
		neg_d   = neg_q;
		accum_d = accum_q;
		step    = 1'b0;
		base    = ilp_pkg::BASE_DEC;
		case (mode_q)
			ilp_pkg::MODE_START: begin
				if (chars.ch == ilp_pkg::CharZero) begin
					mode_d = ilp_pkg::MODE_ZERO;
				end else if (chars.ch == ilp_pkg::CharMinus) begin
					neg_d  = 1'b1;
					mode_d = ilp_pkg::MODE_DEC;
				end else begin
					mode_d = ilp_pkg::MODE_DEC;
					step   = 1'b1;
				end
			end
			ilp_pkg::MODE_ZERO: begin
				if (chars.ch == ilp_pkg::CharX) begin
					mode_d = ilp_pkg::MODE_HEX;
				end else if (chars.ch == ilp_pkg::CharD) begin
					mode_d = ilp_pkg::MODE_DEC_P;
				end else if (chars.ch == ilp_pkg::CharC) begin
					mode_d = ilp_pkg::MODE_OCT_P;
				end else if (chars.ch == ilp_pkg::CharB) begin
					mode_d = ilp_pkg::MODE_BIN_P;
				end else begin
					mode_d = ilp_pkg::MODE_OCT_L;
					base   = ilp_pkg::BASE_OCT;
					step   = 1'b1;
				end
			end
			ilp_pkg::MODE_HEX: begin
				base = ilp_pkg::BASE_HEX;
				step = (chars.ch != ilp_pkg::CharUnder);
			end
			ilp_pkg::MODE_DEC_P: begin
				step = (chars.ch != ilp_pkg::CharUnder);
			end
			ilp_pkg::MODE_OCT_P: begin
				base = ilp_pkg::BASE_OCT;
				step = (chars.ch != ilp_pkg::CharUnder);
			end
			ilp_pkg::MODE_BIN_P: begin
				base = ilp_pkg::BASE_BIN;
				step = (chars.ch != ilp_pkg::CharUnder);
			end
			ilp_pkg::MODE_OCT_L: begin
				base = ilp_pkg::BASE_OCT;
				step = 1'b1;
			end
			ilp_pkg::MODE_DEC: begin
				step = 1'b1;
			end
			ilp_pkg::MODE_HALT: begin
				step = 1'b0;
			end
			default: begin
				mode_d = ilp_pkg::MODE_HALT;
			end
		endcase

		// Hex takes a non-digit as zero; the other bases halt on it.
		if (step) begin
			if (dig.ok || base == ilp_pkg::BASE_HEX) begin
				accum_d = scaled + {{(ilp_pkg::ValueW-ilp_pkg::DigitW){1'b0}},
					(dig.ok ? dig.val : {ilp_pkg::DigitW{1'b0}})};
			end else begin
				mode_d = ilp_pkg::MODE_HALT;
			end
		end
	end

	// Parser state: advance on each byte, drop back to start on the terminator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= ilp_pkg::MODE_START;
			neg_q   <= 1'b0;
			accum_q <= '0;
		end else if (acc) begin
			if (chars.ch == ilp_pkg::CharNul) begin
				mode_q  <= ilp_pkg::MODE_START;
				neg_q   <= 1'b0;
				accum_q <= '0;
			end else begin
				mode_q  <= mode_d;
				neg_q   <= neg_d;
				accum_q <= accum_d;
			end
		end
	end

	// Output register: load on the terminator, hold until taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (acc && chars.ch == ilp_pkg::CharNul) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && chars.ch == ilp_pkg::CharNul) begin
			res_value_q <= neg_q ? ({ilp_pkg::ValueW{1'b0}} - accum_q) : accum_q;
		end
	end

	a_term_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && chars.ch == ilp_pkg::CharNul) |=> res_valid_q)
		else $error("terminator did not load a result");

	a_term_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && chars.ch == ilp_pkg::CharNul) |=>
		(mode_q == ilp_pkg::MODE_START && accum_q == '0 && !neg_q))
		else $error("parser state not cleared after terminator");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && chars.ch != ilp_pkg::CharNul) |=>
		(res_valid_q == $past(res_valid_q && !result.ready)))
		else $error("result raised without a terminator");

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == ilp_pkg::MODE_HALT && acc && chars.ch != ilp_pkg::CharNul) |=>
		($stable(accum_q) && mode_q == ilp_pkg::MODE_HALT))
		else $error("halted conversion changed the accumulator");

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;

	// Generous ceiling: about 1150 bytes, with ample room for random idling
	// and result back-pressure on top.
	localparam int unsigned CycleLimit = 200000;
	localparam int unsigned ByteTarget = 1150;
	localparam int unsigned DrainCycles = 20;

	logic clk;
	logic arst_n;

	ilp_ch_if    chars_if ();
	ilp_value_if result_if ();

	integer_literal_parser_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars_if),
		.result (result_if)
	);

	// Bytes still to be sent, NUL-terminated literals back to back
	logic [ilp_pkg::CharW-1:0]  string_bytes[$];
	// Parsed values awaiting their result request
	logic [ilp_pkg::ValueW-1:0] expected_values[$];

	// Predicted parser state
	ilp_pkg::mode_t             lit_mode;
	logic                       lit_neg;
	logic [ilp_pkg::ValueW-1:0] lit_acc;

	bit                         ch_fire;
	bit                         calm;
	bit                         emit;
	logic [ilp_pkg::ValueW-1:0] emit_value;
	int unsigned                cycles;
	int unsigned                fail_count;

	always #5 clk = ~clk;

	// Digit value of c in the given radix; zero return means not a digit.
	function automatic bit digit_of(input logic [ilp_pkg::CharW-1:0] c,
			input int unsigned radix, output logic [ilp_pkg::ValueW-1:0] d);
		int unsigned v;
		if (c >= ilp_pkg::CharZero && c <= ilp_pkg::CharZero + 9) begin
			v = int'(c) - int'(ilp_pkg::CharZero);
		end else if (c >= ilp_pkg::CharUpperA && c <= ilp_pkg::CharUpperA + 5) begin
			v = int'(c) - int'(ilp_pkg::CharUpperA) + 10;
		end else if (c >= ilp_pkg::CharLowerA && c <= ilp_pkg::CharLowerA + 5) begin
			v = int'(c) - int'(ilp_pkg::CharLowerA) + 10;
		end else begin
			return 1'b0;
		end
		if (v >= radix) begin
			return 1'b0;
		end
		d = ilp_pkg::ValueW'(v);
		return 1'b1;
	endfunction

	// Accumulate a digit in one of the stopping bases, or freeze the value.
	function automatic void take_digit(input logic [ilp_pkg::CharW-1:0] c,
			input int unsigned radix);
		logic [ilp_pkg::ValueW-1:0] d;
		if (digit_of(c, radix, d)) begin
			lit_acc = lit_acc * radix + d;
		end else begin
			lit_mode = ilp_pkg::MODE_HALT;
		end
	endfunction

	// Advance the predicted parser by one byte; a NUL yields the finished value.
	task automatic parse_byte(input logic [ilp_pkg::CharW-1:0] c, output bit done,
			output logic [ilp_pkg::ValueW-1:0] v);
		logic [ilp_pkg::ValueW-1:0] d;
		done = 1'b0;
		v = '0;
		if (c == ilp_pkg::CharNul) begin
			done = 1'b1;
			v = lit_neg ? -lit_acc : lit_acc;
			lit_mode = ilp_pkg::MODE_START;
			lit_neg = 1'b0;
			lit_acc = '0;
		end else begin
			case (lit_mode)
				ilp_pkg::MODE_START: begin
					if (c == ilp_pkg::CharZero) begin
						lit_mode = ilp_pkg::MODE_ZERO;
					end else if (c == ilp_pkg::CharMinus) begin
						lit_neg = 1'b1;
						lit_mode = ilp_pkg::MODE_DEC;
					end else begin
						lit_mode = ilp_pkg::MODE_DEC;
						take_digit(c, 10);
					end
				end
				ilp_pkg::MODE_ZERO: begin
					if (c == ilp_pkg::CharX) begin
						lit_mode = ilp_pkg::MODE_HEX;
					end else if (c == ilp_pkg::CharD) begin
						lit_mode = ilp_pkg::MODE_DEC_P;
					end else if (c == ilp_pkg::CharC) begin
						lit_mode = ilp_pkg::MODE_OCT_P;
					end else if (c == ilp_pkg::CharB) begin
						lit_mode = ilp_pkg::MODE_BIN_P;
					end else begin
						// legacy octal: this byte is already the first digit
						lit_mode = ilp_pkg::MODE_OCT_L;
						take_digit(c, 8);
					end
				end
				ilp_pkg::MODE_HEX: begin
					// hex never stops; a non-digit shifts in a zero
					if (c != ilp_pkg::CharUnder) begin
						if (!digit_of(c, 16, d)) begin
							d = '0;
						end
						lit_acc = lit_acc * 16 + d;
					end
				end
				ilp_pkg::MODE_DEC_P: begin
					if (c != ilp_pkg::CharUnder) begin
						take_digit(c, 10);
					end
				end
				ilp_pkg::MODE_OCT_P: begin
					if (c != ilp_pkg::CharUnder) begin
						take_digit(c, 8);
					end
				end
				ilp_pkg::MODE_BIN_P: begin
					if (c != ilp_pkg::CharUnder) begin
						take_digit(c, 2);
					end
				end
				ilp_pkg::MODE_OCT_L: take_digit(c, 8);
				ilp_pkg::MODE_DEC:   take_digit(c, 10);
				default:             lit_mode = ilp_pkg::MODE_HALT;
			endcase
		end
	endtask

	task automatic push_literal(input string s);
		for (int i = 0; i < s.len(); i++) begin
			string_bytes.push_back(s[i]);
		end
		string_bytes.push_back(ilp_pkg::CharNul);
	endtask

	// Pick one body byte: mostly digits of the radix, some underscores where
	// they are skipped, and a sprinkling of arbitrary non-zero bytes to break
	// the literal. Radix zero means pure noise.
	function automatic logic [ilp_pkg::CharW-1:0] pick_char(input int unsigned radix,
			input bit skips_under);
		int unsigned r;
		r = $urandom_range(0, 99);
		if (radix == 0 || r < 5) begin
			return ilp_pkg::CharW'($urandom_range(1, 255));
		end
		if (skips_under && r < 12) begin
			return ilp_pkg::CharUnder;
		end
		if (radix == 16 && r < 40) begin
			return ilp_pkg::CharW'(($urandom_range(0, 1) ? ilp_pkg::CharLowerA :
				ilp_pkg::CharUpperA) + $urandom_range(0, 5));
		end
		return ilp_pkg::CharW'(ilp_pkg::CharZero +
			$urandom_range(0, (radix > 10) ? 9 : radix - 1));
	endfunction

	task automatic push_random_literal();
		int unsigned kind;
		int unsigned n;
		int unsigned radix;
		bit          skips_under;
		kind = $urandom_range(0, 99);
		// mostly short bodies, some long enough to wrap the accumulator
		n = ($urandom_range(0, 99) < 15) ? $urandom_range(16, 24) : $urandom_range(0, 12);
		radix = 10;
		skips_under = 1'b1;
		if (kind < 18) begin
			string_bytes.push_back(ilp_pkg::CharZero);
			string_bytes.push_back(ilp_pkg::CharX);
			radix = 16;
		end else if (kind < 30) begin
			string_bytes.push_back(ilp_pkg::CharZero);
			string_bytes.push_back(ilp_pkg::CharD);
		end else if (kind < 42) begin
			string_bytes.push_back(ilp_pkg::CharZero);
			string_bytes.push_back(ilp_pkg::CharC);
			radix = 8;
		end else if (kind < 54) begin
			string_bytes.push_back(ilp_pkg::CharZero);
			string_bytes.push_back(ilp_pkg::CharB);
			radix = 2;
			n = n * 3;
		end else if (kind < 66) begin
			string_bytes.push_back(ilp_pkg::CharZero);
			radix = 8;
			skips_under = 1'b0;
		end else if (kind < 84) begin
			if ($urandom_range(0, 2) == 0) begin
				string_bytes.push_back(ilp_pkg::CharMinus);
			end
			skips_under = 1'b0;
		end else begin
			radix = 0;
			skips_under = 1'b0;
		end
		for (int i = 0; i < n; i++) begin
			string_bytes.push_back(pick_char(radix, skips_under));
		end
		string_bytes.push_back(ilp_pkg::CharNul);
	endtask

	// Request monitor: sample both channels on the rising edge, feed accepted
	// bytes through the predictor and check each result against the oldest
	// expectation.
	always @(posedge clk) begin
		if (arst_n) begin
			if (chars_if.valid && chars_if.ready) begin
				parse_byte(chars_if.ch, emit, emit_value);
				if (emit) begin
					expected_values.push_back(emit_value);
				end
			end
			if (result_if.valid && result_if.ready) begin
				if (expected_values.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %0d", $time,
						result_if.value);
					fail_count++;
				end else begin
					if (result_if.value !== expected_values[0]) begin
						$display("%0t: value mismatch, expected %0d, actual %0d", $time,
							$signed(expected_values[0]), result_if.value);
						fail_count++;
					end
					void'(expected_values.pop_front());
				end
			end
			ch_fire <= chars_if.valid && chars_if.ready;
		end
	end

	// Driver: change inputs on the falling edge. Hold the current byte until
	// it is taken, then advance or idle at random; throttle result ready alike.
	always @(negedge clk) begin
		if (arst_n) begin
			// a stretch with no idling on either side
			calm = (cycles >= 600 && cycles < 1100);
			if (!chars_if.valid || ch_fire) begin
				if (string_bytes.size() > 0 && (calm || $urandom_range(0, 99) >= 36)) begin
					chars_if.valid <= 1'b1;
					chars_if.ch <= string_bytes.pop_front();
				end else begin
					chars_if.valid <= 1'b0;
				end
			end
			result_if.ready <= calm || ($urandom_range(0, 99) >= 36);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		chars_if.valid = 1'b0;
		chars_if.ch = '0;
		result_if.ready = 1'b0;
		lit_mode = ilp_pkg::MODE_START;
		lit_neg = 1'b0;
		lit_acc = '0;
		ch_fire = 1'b0;
		calm = 1'b0;
		cycles = 0;
		fail_count = 0;

		// directed literals: empty, lone zero and lone minus first
		push_literal("");
		push_literal("0");
		push_literal("-");
		push_literal("0x7fG_f");            // hex non-digit counts as zero
		push_literal("0xFFFFFFFFFFFFFFFFF"); // wraps past 64 bits
		push_literal("0d12_9");
		push_literal("0c17_9");             // invalid digit freezes the value
		push_literal("0b10_12");
		push_literal("0754");
		push_literal("07_5");               // underscore stops legacy octal
		push_literal("08");
		push_literal("12_3");               // and plain decimal too
		push_literal("-42x9");              // sign kept after a stop
		push_literal("-9223372036854775808");
		string_bytes.push_back(8'hFF);      // top bit set on the first byte
		push_literal("1");

		while (string_bytes.size() < ByteTarget) begin
			push_random_literal();
		end

		// hold reset, then release it away from the rising edge
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// drain: all bytes sent, every result back, then a short quiet tail
		@(negedge clk);
		while (string_bytes.size() > 0 || chars_if.valid) begin
			@(negedge clk);
		end
		while (expected_values.size() > 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);

		if (fail_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hw/rtl/ilp_pkg.sv
hw/rtl/ilp_ch_if.sv
hw/rtl/ilp_value_if.sv
hw/rtl/ilp_digit.sv
hw/rtl/integer_literal_parser_unit.sv
tb/sv/tb_top.sv
